>>> rtl/wfc_pkg.sv
// Shared types, codes and constants for the wall-follow drive controller.
package wfc_pkg;

  localparam int DIST_W = 13;
  localparam int VEL_W  = 16;
  localparam int ANG_W  = 16;
  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;

  // input opcodes
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_ENABLE  = 2'd1;
  localparam logic [1:0] OP_DISABLE = 2'd2;

  // modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_FOLLOW = 2'd2;
  localparam logic [1:0] MODE_TURN   = 2'd3;

  // drive commands
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_DRIVE = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // config register indexes
  localparam logic [2:0] REG_SET_DIST  = 3'd0;
  localparam logic [2:0] REG_TURN_DIST = 3'd1;
  localparam logic [2:0] REG_ROT_DIST  = 3'd2;
  localparam logic [2:0] REG_KP_WALL   = 3'd3;
  localparam logic [2:0] REG_KP_ROT    = 3'd4;
  localparam logic [2:0] REG_FIND_SPD  = 3'd5;
  localparam logic [2:0] REG_FOLLOW_SPD = 3'd6;
  localparam logic [2:0] REG_ROT_SPD   = 3'd7;

  // work classes handed from front to back
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_STOP   = 3'd1;
  localparam logic [2:0] ACT_SEEK   = 3'd2;
  localparam logic [2:0] ACT_FOLLOW = 3'd3;
  localparam logic [2:0] ACT_TURN   = 3'd4;

  // divide by 125: floor(m / 125) = (m * RECIP_125) >> RECIP_SHIFT for m < 2^22
  localparam int RECIP_SHIFT = 29;
  localparam logic [22:0] RECIP_125 = 23'd4294968;
  localparam int DIVQ_W = 22;
  // any magnitude at or above this saturates either way
  localparam logic [DIVQ_W-1:0] VY_CLAMP = 22'd4096125;
  localparam logic [PROD_W-1:0] HALF_125 = PROD_W'(62);
  localparam logic [PROD_W-1:0] HALF_256 = PROD_W'(128);

  localparam logic [VEL_W-1:0] VEL_MAX = 16'h7FFF;
  localparam logic [VEL_W-1:0] VEL_MIN = 16'h8000;

  typedef struct packed {
    logic [DIST_W-1:0]       set_distance;
    logic [DIST_W-1:0]       turn_distance;
    logic [DIST_W-1:0]       rot_distance;
    logic signed [VEL_W-1:0] kp_wall;
    logic signed [VEL_W-1:0] kp_rot;
    logic signed [VEL_W-1:0] find_speed;
    logic signed [VEL_W-1:0] follow_speed;
    logic signed [VEL_W-1:0] rotation_speed;
  } cfg_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] mode;
  } ctl_t;

  // atan(2^-i) in Q3.12
  function automatic logic signed [ANG_W-1:0] atan_q12(input logic [3:0] i);
    logic signed [ANG_W-1:0] a;
    case (i)
      4'd0:    a = 16'sd3217;
      4'd1:    a = 16'sd1899;
      4'd2:    a = 16'sd1003;
      4'd3:    a = 16'sd509;
      4'd4:    a = 16'sd256;
      4'd5:    a = 16'sd128;
      4'd6:    a = 16'sd64;
      4'd7:    a = 16'sd32;
      4'd8:    a = 16'sd16;
      4'd9:    a = 16'sd8;
      4'd10:   a = 16'sd4;
      4'd11:   a = 16'sd2;
      4'd12:   a = 16'sd1;
      default: a = 16'sd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/wfc_front.sv
// Front end: accepts transactions, tracks the mode and classifies the work.
module wfc_front #(
  parameter int RANGE_BITS = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [1:0]                  opcode,
  input  logic [wfc_pkg::DIST_W-1:0]  range_front,
  input  logic [wfc_pkg::DIST_W-1:0]  range_side_front,
  input  logic [wfc_pkg::DIST_W-1:0]  range_side_rear,
  input  wfc_pkg::cfg_t               cfg,
  output wfc_pkg::ctl_t               push_ctl,
  output logic [RANGE_BITS-1:0]       push_sf,
  output logic [RANGE_BITS-1:0]       push_sr
);
  import wfc_pkg::*;

  localparam int CMP_W = ((RANGE_BITS > DIST_W) ? RANGE_BITS : DIST_W) + 1;

  logic [1:0]            mode;
  logic [1:0]            mode_next;
  logic [2:0]            action;
  logic [RANGE_BITS-1:0] f_r;
  logic [CMP_W-1:0]      sum;
  logic [CMP_W-1:0]      two_set;
  logic [CMP_W-1:0]      front_x;

  assign f_r     = RANGE_BITS'(range_front);
  assign push_sf = RANGE_BITS'(range_side_front);
  assign push_sr = RANGE_BITS'(range_side_rear);
  assign sum     = CMP_W'(push_sf) + CMP_W'(push_sr);
  assign two_set = CMP_W'({cfg.set_distance, 1'b0});
  assign front_x = CMP_W'(f_r);

  always_comb begin
    mode_next = mode;
    action    = ACT_NONE;
    case (opcode)
      OP_ENABLE: mode_next = MODE_FIND;
      OP_DISABLE: begin
        mode_next = MODE_IDLE;
        action    = ACT_STOP;
      end
      OP_SAMPLE: begin
        case (mode)
          MODE_FIND: begin
            if (sum <= two_set) mode_next = MODE_FOLLOW;
            else action = ACT_SEEK;
          end
          MODE_FOLLOW: begin
            if (front_x <= CMP_W'(cfg.turn_distance)) mode_next = MODE_TURN;
            else action = ACT_FOLLOW;
          end
          MODE_TURN: begin
            if (front_x >= CMP_W'(cfg.rot_distance)) mode_next = MODE_FIND;
            else action = ACT_TURN;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign push_ctl.action = action;
  assign push_ctl.mode   = mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

>>> rtl/wfc_queue.sv
// Two-entry queue between the front and back ends.
module wfc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty,
  output logic             full
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

>>> rtl/wfc_back.sv
// Back end: CORDIC heading, shared multiplier for gains, and output register.
module wfc_back #(
  parameter int SENSOR_SPACING = 100,
  parameter int RANGE_BITS     = 13,
  parameter int CORDIC_STEPS   = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  wfc_pkg::cfg_t                      cfg,
  input  logic                               q_not_empty,
  input  wfc_pkg::ctl_t                      q_ctl,
  input  logic [RANGE_BITS-1:0]              q_sf,
  input  logic [RANGE_BITS-1:0]              q_sr,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         drive_command,
  output logic signed [wfc_pkg::VEL_W-1:0]   vel_x,
  output logic signed [wfc_pkg::VEL_W-1:0]   vel_y,
  output logic signed [wfc_pkg::VEL_W-1:0]   vel_turn,
  output logic [1:0]                         mode_now
);
  import wfc_pkg::*;

  localparam int MAX_W = (RANGE_BITS > 10) ? RANGE_BITS : 10;
  localparam int CW    = MAX_W + 19;
  localparam int SUM_W = ((RANGE_BITS > DIST_W) ? RANGE_BITS : DIST_W) + 1;
  localparam int ERR_W = SUM_W + 1;
  localparam int NSTEP = (CORDIC_STEPS > 16) ? 16 : CORDIC_STEPS;
  localparam int TQ_W  = PROD_W - 8;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CORD = 3'd1;
  localparam logic [2:0] ST_MW   = 3'd2;
  localparam logic [2:0] ST_MA   = 3'd3;
  localparam logic [2:0] ST_MR   = 3'd4;
  localparam logic [2:0] ST_MT   = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]               state;
  logic [4:0]               cnt;
  logic signed [CW-1:0]     x;
  logic signed [CW-1:0]     y;
  logic signed [ANG_W-1:0]  z;
  logic signed [CW-1:0]     xs;
  logic signed [CW-1:0]     ys;
  logic signed [ERR_W-1:0]  err;
  logic signed [RANGE_BITS:0] dy;
  logic [SUM_W-1:0]         sum;
  logic [1:0]               f_mode;
  logic                     ysign;
  logic [DIVQ_W-1:0]        m;
  logic signed [VEL_W-1:0]  vy_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0]        pmag;
  logic [PROD_W-1:0]        pmag_h;
  logic [DIVQ_W-1:0]        m_next;
  logic [16:0]              vq;
  logic signed [VEL_W-1:0]  vy_next;
  logic [TQ_W-1:0]          tq;
  logic signed [VEL_W-1:0]  vt_next;
  logic                     out_free;
  logic                     direct_ld;
  logic                     fin_ld;
  logic [1:0]               cmd_d;
  logic signed [VEL_W-1:0]  vx_d;
  logic signed [VEL_W-1:0]  vy_d;
  logic signed [VEL_W-1:0]  vt_d;

  assign out_free = !out_valid || !out_stall;
  assign sum      = SUM_W'(q_sf) + SUM_W'(q_sr);
  assign dy       = (RANGE_BITS + 1)'(q_sr) - (RANGE_BITS + 1)'(q_sf);
  assign xs       = x >>> cnt[3:0];
  assign ys       = y >>> cnt[3:0];

  always_comb begin
    q_pop     = 1'b0;
    direct_ld = 1'b0;
    if (state == ST_IDLE && q_not_empty) begin
      if (q_ctl.action == ACT_FOLLOW) begin
        q_pop = 1'b1;
      end else if (out_free) begin
        q_pop     = 1'b1;
        direct_ld = 1'b1;
      end
    end
  end

  assign fin_ld = (state == ST_FIN) && out_free;

  // results that need no arithmetic
  always_comb begin
    cmd_d = CMD_NONE;
    vx_d  = '0;
    vy_d  = '0;
    vt_d  = '0;
    case (q_ctl.action)
      ACT_STOP: cmd_d = CMD_STOP;
      ACT_SEEK: begin
        cmd_d = CMD_DRIVE;
        vy_d  = cfg.find_speed;
      end
      ACT_TURN: begin
        cmd_d = CMD_DRIVE;
        vt_d  = cfg.rotation_speed;
      end
      default: ;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      ST_MW: begin
        mul_a = MUL_W'(cfg.kp_wall);
        mul_b = MUL_W'(err);
      end
      ST_MR: begin
        mul_a = MUL_W'(m);
        mul_b = MUL_W'(RECIP_125);
      end
      default: begin
        mul_a = MUL_W'(cfg.kp_rot);
        mul_b = MUL_W'(z);
      end
    endcase
  end

  // magnitude, rounding and saturation
  always_comb begin
    pmag   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    pmag_h = pmag + HALF_125;
    m_next = (pmag_h >= PROD_W'(VY_CLAMP)) ? VY_CLAMP : pmag_h[DIVQ_W-1:0];

    vq = prod[RECIP_SHIFT +: 17];
    if (!ysign) begin
      vy_next = (vq > 17'd32767) ? VEL_MAX : vq[VEL_W-1:0];
    end else begin
      vy_next = (vq > 17'd32768) ? VEL_MIN : -vq[VEL_W-1:0];
    end

    tq = TQ_W'((pmag + HALF_256) >> 8);
    if (!prod[PROD_W-1]) begin
      vt_next = (tq > TQ_W'(32767)) ? VEL_MAX : tq[VEL_W-1:0];
    end else begin
      vt_next = (tq > TQ_W'(32768)) ? VEL_MIN : -tq[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (q_pop && !direct_ld) state <= ST_CORD;
        ST_CORD: if (cnt == 5'(NSTEP)) state <= ST_MW;
        ST_MW:   state <= ST_MA;
        ST_MA:   state <= ST_MR;
        ST_MR:   state <= ST_MT;
        ST_MT:   state <= ST_FIN;
        ST_FIN:  if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x      <= CW'(SENSOR_SPACING) <<< 16;
        y      <= CW'(dy) <<< 16;
        z      <= '0;
        cnt    <= '0;
        err    <= ERR_W'(sum) - ERR_W'({cfg.set_distance, 1'b0});
        f_mode <= q_ctl.mode;
      end
      ST_CORD: begin
        if (cnt != 5'(NSTEP)) begin
          if (!y[CW-1]) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atan_q12(cnt[3:0]);
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atan_q12(cnt[3:0]);
          end
          cnt <= cnt + 5'd1;
        end
      end
      ST_MW: prod <= mul_a * mul_b;
      ST_MA: begin
        m     <= m_next;
        ysign <= prod[PROD_W-1];
      end
      ST_MR: prod <= mul_a * mul_b;
      ST_MT: begin
        vy_r <= vy_next;
        prod <= mul_a * mul_b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (direct_ld || fin_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (direct_ld) begin
      drive_command <= cmd_d;
      vel_x         <= vx_d;
      vel_y         <= vy_d;
      vel_turn      <= vt_d;
      mode_now      <= q_ctl.mode;
    end else if (fin_ld) begin
      drive_command <= CMD_DRIVE;
      vel_x         <= cfg.follow_speed;
      vel_y         <= vy_r;
      vel_turn      <= vt_next;
      mode_now      <= f_mode;
    end
  end

endmodule

>>> rtl/wall_follow_controller_top.sv
// Top level of the wall-follow drive controller.
//
// Input channel (in_valid / in_stall): one transaction per command, either a
// range sample, enable or disable. Output channel (out_valid / out_stall): one
// transaction per input, carrying the drive command, three velocities and the
// mode after the step. Config writes (cfg_valid / cfg_ready, cfg_index,
// cfg_data) are always taken; write only while the block is idle.
// The front end updates the mode on accept and hands the job to a two-entry
// queue; the back end finishes it into the output register.
// A job waits in the queue; the back end moves any job but a follow sample
// straight into the output register. A follow sample leaves the queue, runs
// the CORDIC loop and then the shared multiplier and output register. Other
// jobs drain one per cycle while the back end is idle and the output is not
// stalled. in_stall rises when the queue is full.
// Reset clears the mode to idle, loads the register defaults and empties the
// queue and output register. A stalled receiver holds the result and lets the
// queue fill before the input side stalls.
module wall_follow_controller_top #(
  parameter int SENSOR_SPACING = 100,
  parameter int RANGE_BITS     = 13,
  parameter int CORDIC_STEPS   = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic [wfc_pkg::DIST_W-1:0]        range_front,
  input  logic [wfc_pkg::DIST_W-1:0]        range_side_front,
  input  logic [wfc_pkg::DIST_W-1:0]        range_side_rear,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        drive_command,
  output logic signed [wfc_pkg::VEL_W-1:0]  vel_x,
  output logic signed [wfc_pkg::VEL_W-1:0]  vel_y,
  output logic signed [wfc_pkg::VEL_W-1:0]  vel_turn,
  output logic [1:0]                        mode_now,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [wfc_pkg::VEL_W-1:0]         cfg_data
);
  import wfc_pkg::*;

  localparam int Q_W = $bits(ctl_t) + 2 * RANGE_BITS;

  cfg_t                  cfg;
  logic                  in_accept;
  ctl_t                  push_ctl;
  logic [RANGE_BITS-1:0] push_sf;
  logic [RANGE_BITS-1:0] push_sr;
  logic [Q_W-1:0]        q_data;
  logic                  q_not_empty;
  logic                  q_pop;
  ctl_t                  q_ctl;
  logic [RANGE_BITS-1:0] q_sf;
  logic [RANGE_BITS-1:0] q_sr;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_distance   <= 13'd150;
      cfg.turn_distance  <= 13'd200;
      cfg.rot_distance   <= 13'd400;
      cfg.kp_wall        <= 16'sd256;
      cfg.kp_rot         <= 16'sd256;
      cfg.find_speed     <= 16'sd1024;
      cfg.follow_speed   <= 16'sd1024;
      cfg.rotation_speed <= 16'sd1024;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SET_DIST:   cfg.set_distance   <= cfg_data[DIST_W-1:0];
        REG_TURN_DIST:  cfg.turn_distance  <= cfg_data[DIST_W-1:0];
        REG_ROT_DIST:   cfg.rot_distance   <= cfg_data[DIST_W-1:0];
        REG_KP_WALL:    cfg.kp_wall        <= cfg_data;
        REG_KP_ROT:     cfg.kp_rot         <= cfg_data;
        REG_FIND_SPD:   cfg.find_speed     <= cfg_data;
        REG_FOLLOW_SPD: cfg.follow_speed   <= cfg_data;
        REG_ROT_SPD:    cfg.rotation_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  wfc_front #(
    .RANGE_BITS(RANGE_BITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_accept),
    .opcode           (opcode),
    .range_front      (range_front),
    .range_side_front (range_side_front),
    .range_side_rear  (range_side_rear),
    .cfg              (cfg),
    .push_ctl         (push_ctl),
    .push_sf          (push_sf),
    .push_sr          (push_sr)
  );

  wfc_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_data ({push_ctl, push_sf, push_sr}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_not_empty),
    .full      (in_stall)
  );

  assign q_ctl = q_data[Q_W-1 -: $bits(ctl_t)];
  assign q_sf  = q_data[2*RANGE_BITS-1 -: RANGE_BITS];
  assign q_sr  = q_data[RANGE_BITS-1:0];

  wfc_back #(
    .SENSOR_SPACING (SENSOR_SPACING),
    .RANGE_BITS     (RANGE_BITS),
    .CORDIC_STEPS   (CORDIC_STEPS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_not_empty   (q_not_empty),
    .q_ctl         (q_ctl),
    .q_sf          (q_sf),
    .q_sr          (q_sr),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive_command (drive_command),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .vel_turn      (vel_turn),
    .mode_now      (mode_now)
  );

endmodule
